// ===== hdl/lra_pkg.sv =====
// Shared constants, types and small helpers for the largest-region area block.
// No dependencies; every other file in hdl but lra_ram imports this package.
package lra_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int CELL_CAP = MAX_ROWS * MAX_COLS;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int CELL_W = $clog2(CELL_CAP);
  localparam int CNT_W  = CELL_W + 1;
  localparam int POS_W  = ROW_W + COL_W;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int AREA_W    = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  localparam int NBR_W = 3;
  localparam logic [NBR_W-1:0] NBR_LAST = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_step;
    logic scan_rd;
    logic seed;
    logic scan_adv;
    logic region_end;
    logic pop;
    logic pop_latch;
    logic nb_rd;
    logic nb_chk;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic grid_end;
    logic clr_last;
    logic scan_open;
    logic scan_last;
    logic q_empty;
    logic nb_last;
    logic out_busy;
  } dp_status_t;

  // Row offset of neighbour k (eight surrounding cells).
  function automatic logic signed [1:0] nbr_dr(input logic [NBR_W-1:0] k);
    logic signed [1:0] d;
    case (k)
      3'd0, 3'd1, 3'd2: d = -2'sd1;
      3'd3, 3'd4:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  // Column offset of neighbour k.
  function automatic logic signed [1:0] nbr_dc(input logic [NBR_W-1:0] k);
    logic signed [1:0] d;
    case (k)
      3'd0, 3'd3, 3'd5: d = -2'sd1;
      3'd1, 3'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  function automatic logic [ROW_W:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [ROW_W:0] r;
    if (v == '0) r = (ROW_W+1)'(1);
    else if (int'(v) > MAX_ROWS) r = (ROW_W+1)'(MAX_ROWS);
    else r = (ROW_W+1)'(v);
    return r;
  endfunction

  function automatic logic [COL_W:0] clamp_cols(input logic [CFG_W-1:0] v);
    logic [COL_W:0] r;
    if (v == '0) r = (COL_W+1)'(1);
    else if (int'(v) > MAX_COLS) r = (COL_W+1)'(MAX_COLS);
    else r = (COL_W+1)'(v);
    return r;
  endfunction

endpackage

// ===== hdl/lra_if.sv =====
// Valid/ready channel interfaces: grid cells in, region area out.
// Depends on lra_pkg.
interface lra_cell_if;
  logic valid;
  logic ready;
  logic cell_is_land;
  logic last_cell;
  modport source (output valid, output cell_is_land, output last_cell, input ready);
  modport sink (input valid, input cell_is_land, input last_cell, output ready);
endinterface

interface lra_area_if;
  import lra_pkg::*;
  logic              valid;
  logic              ready;
  logic [AREA_W-1:0] max_area;
  modport source (output valid, output max_area, input ready);
  modport sink (input valid, input max_area, output ready);
endinterface

// ===== hdl/lra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lra_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/lra_ctrl.sv =====
// Sequencer for load, visited clear, scan and breadth-first fill.
// Depends on lra_pkg; drives lra_dpath through command and status structs.
module lra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  lra_pkg::dp_status_t st,
  output lra_pkg::dp_cmd_t    cmd
);
  import lra_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CLEAR    = 9'b000000010,
    S_SCAN_RD  = 9'b000000100,
    S_SCAN_CHK = 9'b000001000,
    S_POP      = 9'b000010000,
    S_POP_WAIT = 9'b000100000,
    S_NB_RD    = 9'b001000000,
    S_NB_CHK   = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = 1'b1;
        if (st.grid_end) state_next = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (st.scan_open) begin
          cmd.seed   = 1'b1;
          state_next = S_POP;
        end else if (st.scan_last) begin
          state_next = S_DONE;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_POP: begin
        if (st.q_empty) begin
          cmd.region_end = 1'b1;
          if (st.scan_last) begin
            state_next = S_DONE;
          end else begin
            cmd.scan_adv = 1'b1;
            state_next   = S_SCAN_RD;
          end
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd.pop_latch = 1'b1;
        state_next    = S_NB_RD;
      end
      S_NB_RD: begin
        cmd.nb_rd  = 1'b1;
        state_next = S_NB_CHK;
      end
      S_NB_CHK: begin
        cmd.nb_chk = 1'b1;
        state_next = st.nb_last ? S_POP : S_NB_RD;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== hdl/lra_dpath.sv =====
// Datapath: config registers, land/visited bitmaps, cell queue, counters.
// Depends on lra_pkg, lra_if and lra_ram.
module lra_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lra_pkg::CFG_W-1:0]       cfg_data,
  lra_cell_if.sink                        grid,
  lra_area_if.source                      result,
  input  lra_pkg::dp_cmd_t                cmd,
  output lra_pkg::dp_status_t             st
);
  import lra_pkg::*;

  logic [CFG_W-1:0] row_count, column_count;
  logic [ROW_W:0]   rows_c, rows_q;
  logic [COL_W:0]   cols_c, cols_q;
  logic [ROW_W+COL_W+1:0] cells_full;
  logic [CNT_W-1:0] cells_c, cells_q, load_index, loaded_q;
  logic [CELL_W-1:0] cells_m1, clr_ptr, sp;
  logic [ROW_W-1:0] sr, cur_r, nb_r_q;
  logic [COL_W-1:0] sc, cur_c, nb_c_q, cols_m1;
  logic [CNT_W-1:0] head, tail, region_cnt, best;
  logic [NBR_W-1:0] nbr;
  logic [CELL_W-1:0] nb_addr, nb_addr_q;
  logic nb_inb, nb_inb_q, nb_open;
  logic signed [ROW_W+1:0] nr_s;
  logic signed [COL_W+1:0] nc_s;
  logic signed [1:0] dr, dc;
  logic [ROW_W+COL_W:0] nb_lin;
  logic fire, write_land;
  logic land_rd, vis_rd;
  logic [POS_W-1:0] q_rd;
  logic vis_we, vis_wdata, q_we;
  logic [CELL_W-1:0] vis_waddr, rd_addr, q_waddr;
  logic [POS_W-1:0] q_wdata;
  logic out_valid;
  logic [AREA_W-1:0] area;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= CFG_W'(MAX_ROWS);
      column_count <= CFG_W'(MAX_COLS);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows_c     = clamp_rows(row_count);
  assign cols_c     = clamp_cols(column_count);
  assign cells_full = {{(COL_W+1){1'b0}}, rows_c} * {{(ROW_W+1){1'b0}}, cols_c};
  assign cells_c    = cells_full[CNT_W-1:0];
  assign cells_m1   = CELL_W'(cells_q - CNT_W'(1));
  assign cols_m1    = COL_W'(cols_q - (COL_W+1)'(1));

  assign grid.ready  = cmd.accept;
  assign fire        = grid.valid && cmd.accept;
  assign write_land  = fire && (load_index < cells_c);
  assign st.grid_end = fire && grid.last_cell;

  // Neighbour address
  assign dr     = nbr_dr(nbr);
  assign dc     = nbr_dc(nbr);
  assign nr_s   = $signed({2'b00, cur_r}) + $signed({{ROW_W{dr[1]}}, dr});
  assign nc_s   = $signed({2'b00, cur_c}) + $signed({{COL_W{dc[1]}}, dc});
  assign nb_inb = !nr_s[ROW_W+1] && !nc_s[COL_W+1]
                  && (nr_s[ROW_W:0] < rows_q) && (nc_s[COL_W:0] < cols_q);
  assign nb_lin = {{(COL_W+1){1'b0}}, nr_s[ROW_W-1:0]} * {{ROW_W{1'b0}}, cols_q}
                  + {{(ROW_W+1){1'b0}}, nc_s[COL_W-1:0]};
  assign nb_addr = nb_lin[CELL_W-1:0];

  assign nb_open = nb_inb_q && land_rd && !vis_rd && ({1'b0, nb_addr_q} < loaded_q);

  assign st.clr_last  = (clr_ptr == cells_m1);
  assign st.scan_open = land_rd && !vis_rd && ({1'b0, sp} < loaded_q);
  assign st.scan_last = (sp == cells_m1);
  assign st.q_empty   = (head == tail);
  assign st.nb_last   = (nbr == NBR_LAST);
  assign st.out_busy  = out_valid;

  // Memory port muxing
  assign rd_addr   = cmd.scan_rd ? sp : nb_addr;
  assign vis_we    = cmd.clr_step || cmd.seed || (cmd.nb_chk && nb_open);
  assign vis_wdata = !cmd.clr_step;
  assign vis_waddr = cmd.clr_step ? clr_ptr : (cmd.seed ? sp : nb_addr_q);
  assign q_we      = cmd.seed || (cmd.nb_chk && nb_open);
  assign q_waddr   = cmd.seed ? '0 : tail[CELL_W-1:0];
  assign q_wdata   = cmd.seed ? {sr, sc} : {nb_r_q, nb_c_q};

  lra_ram #(.WIDTH(1), .DEPTH(CELL_CAP)) u_land (
    .clk(clk), .we(write_land), .waddr(load_index[CELL_W-1:0]),
    .wdata(grid.cell_is_land), .raddr(rd_addr), .rdata(land_rd)
  );

  lra_ram #(.WIDTH(1), .DEPTH(CELL_CAP)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr),
    .wdata(vis_wdata), .raddr(rd_addr), .rdata(vis_rd)
  );

  lra_ram #(.WIDTH(POS_W), .DEPTH(CELL_CAP)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr),
    .wdata(q_wdata), .raddr(head[CELL_W-1:0]), .rdata(q_rd)
  );

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (st.grid_end) begin
        load_index <= '0;
      end else if (write_land) begin
        load_index <= load_index + CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan and fill registers
  always_ff @(posedge clk) begin
    if (st.grid_end) begin
      rows_q   <= rows_c;
      cols_q   <= cols_c;
      cells_q  <= cells_c;
      loaded_q <= write_land ? load_index + CNT_W'(1) : cells_c;
      clr_ptr  <= '0;
      sp       <= '0;
      sr       <= '0;
      sc       <= '0;
      best     <= '0;
    end
    if (cmd.clr_step) clr_ptr <= clr_ptr + CELL_W'(1);
    if (cmd.scan_adv) begin
      sp <= sp + CELL_W'(1);
      if (sc == cols_m1) begin
        sc <= '0;
        sr <= sr + ROW_W'(1);
      end else begin
        sc <= sc + COL_W'(1);
      end
    end
    if (cmd.seed) begin
      head       <= '0;
      tail       <= CNT_W'(1);
      region_cnt <= CNT_W'(1);
    end
    if (cmd.region_end && (region_cnt > best)) best <= region_cnt;
    if (cmd.pop) head <= head + CNT_W'(1);
    if (cmd.pop_latch) begin
      {cur_r, cur_c} <= q_rd;
      nbr            <= '0;
    end
    if (cmd.nb_rd) begin
      nb_addr_q <= nb_addr;
      nb_inb_q  <= nb_inb;
      nb_r_q    <= nr_s[ROW_W-1:0];
      nb_c_q    <= nc_s[COL_W-1:0];
    end
    if (cmd.nb_chk) begin
      nbr <= nbr + NBR_W'(1);
      if (nb_open) begin
        tail       <= tail + CNT_W'(1);
        region_cnt <= region_cnt + CNT_W'(1);
      end
    end
    if (cmd.emit) area <= AREA_W'(best);
  end

  assign result.valid    = out_valid;
  assign result.max_area = area;
endmodule

// ===== hdl/largest_region_area_8conn_core.sv =====
// Top level of the largest 8-connected land region block.
// Depends on lra_pkg, lra_if, lra_ctrl and lra_dpath (which uses lra_ram).
//
// Use:
//   grid   - valid/ready sink; one word per cell in row-major order,
//            cell_is_land = 1 for land, last_cell = 1 on the final cell.
//   result - valid/ready source; one word per grid carrying max_area,
//            the cell count of the largest 8-connected land region (0 if none).
//   cfg_*  - write port for row_count (index 0) and column_count (index 1);
//            write only while idle. Counts are clamped to 1..64.
// Cells load one per cycle while the block is idle. After the last cell the
// block clears its visited bitmap, scans every cell and fills each region
// breadth-first: per land cell a queue read, then a read and a check for each
// of the eight neighbours (set by the single read port of the bitmaps), plus
// a check per region to find its queue empty.
// Grid input is held off from the last cell until the result is emitted;
// cells of the next grid are taken while the result word still waits on a
// stalled receiver, and the next result holds until that word is taken.
// Cells beyond rows*columns are dropped. Reset restores both counts to 64
// and clears the sequencer state, the load index and the result valid.
module largest_region_area_8conn_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lra_pkg::CFG_W-1:0]     cfg_data,
  lra_cell_if.sink                      grid,
  lra_area_if.source                    result
);
  import lra_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // Sequencer
  lra_ctrl u_ctrl (
    .clk(clk), .rst(rst), .st(st), .cmd(cmd)
  );

  // Storage and arithmetic
  lra_dpath u_dpath (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .grid(grid), .result(result), .cmd(cmd), .st(st)
  );
endmodule
